FILE: rtl/pid_controller_clamped_integral_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the PID controller unit
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef PID_CONTROLLER_CLAMPED_INTEGRAL_UNIT_ASSERT_SVH
`define PID_CONTROLLER_CLAMPED_INTEGRAL_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PIDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pidc_pkg.sv
// ---------------------------------------------------------------------------
// PID controller package
// Shared request/response types, register indexes and saturation helper.
// ---------------------------------------------------------------------------
package pidc_pkg;

  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 64;

  localparam logic [2:0] REG_KP     = 3'd0;
  localparam logic [2:0] REG_KI     = 3'd1;
  localparam logic [2:0] REG_KD     = 3'd2;
  localparam logic [2:0] REG_TARGET = 3'd3;
  localparam logic [2:0] REG_OFFSET = 3'd4;
  localparam logic [2:0] REG_BOUND  = 3'd5;

  localparam logic [31:0] MS_PER_SECOND = 32'd1000;

  typedef struct packed {
    logic               start;
    logic signed [33:0] a;
    logic signed [32:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic signed [65:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/pid_controller_clamped_integral_unit.sv
// ---------------------------------------------------------------------------
// PID controller with clamped integral
// Q16.16 PID step per sample, built on a serial multiplier and divider.
// ---------------------------------------------------------------------------
// Usage: each request on the s_ channel carries a measurement and a
// millisecond timestamp; exactly one result per request leaves on the m_
// channel with the drive, the error and the integral clamp flag.
// The first request after reset only primes the timestamp; its result, with a
// drive of zero, moves from S_DONE to the output register and raises m_tvalid.
// Every later request runs through the shared units in turn: the integral
// product and divide by 1000, the derivative product and divide by the
// elapsed time, and three gain products. A zero elapsed time skips the
// derivative path. s_tready is high only while the sequencer is idle, so a new
// request is taken only once the last result has left the sequencer. The
// result sits in an output register, so the next request is taken and worked
// on while the receiver stalls; the sequencer then waits until that register
// is free. Reset clears all gains, the setpoint, the bound, the integral and
// the primed flag. Registers are to be written over the APB port only while
// idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module pid_controller_clamped_integral_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] measured_value, [63:32] time_ms
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] drive_value, [63:32] current_error,
                                 // [64] integral_clamped, [71:65] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "pid_controller_clamped_integral_unit_assert.svh"

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_MI   = 10'b0000000010,
    S_DI   = 10'b0000000100,
    S_INT  = 10'b0000001000,
    S_MD   = 10'b0000010000,
    S_DD   = 10'b0000100000,
    S_MP   = 10'b0001000000,
    S_MK   = 10'b0010000000,
    S_MKD  = 10'b0100000000,
    S_DONE = 10'b1000000000
  } state_t;

  state_t state;

  logic signed [31:0] kp, ki, kd, target, offset;
  logic [30:0]        bound;

  logic               primed;
  logic signed [31:0] integral_sum, error_now, error_before, deriv, drive_r;
  logic [31:0]        time_before, elapsed;
  logic               clamp_r, quo_neg, go;
  logic signed [55:0] step_q;
  logic signed [51:0] acc;

  logic signed [31:0] o_drive, o_error;
  logic               o_clamp, o_valid;

  pidc_pkg::mul_req_t mul_req;
  pidc_pkg::mul_rsp_t mul_rsp;
  pidc_pkg::div_req_t div_req;
  pidc_pkg::div_rsp_t div_rsp;

  logic signed [31:0] meas;
  logic [31:0]        now;
  logic signed [33:0] err_full, diff;
  logic signed [63:0] err_wide, deriv_wide, total_wide;
  logic [65:0]        p_mag;
  logic signed [56:0] sum, bound_pos;
  logic signed [63:0] dq;
  logic signed [51:0] total;
  logic               wr;

  assign meas = s_tdata[31:0];
  assign now  = s_tdata[63:32];
  assign err_full = 34'(target) + 34'(offset) - 34'(meas);
  assign err_wide = 64'(err_full);
  assign diff = 34'(error_now) - 34'(error_before);
  assign p_mag = mul_rsp.p[65] ? 66'(-mul_rsp.p) : mul_rsp.p;
  assign sum = 57'(integral_sum) + 57'(step_q);
  assign bound_pos = $signed({26'd0, bound});
  assign dq = quo_neg ? -$signed({1'b0, div_rsp.quo[62:0]})
                      : $signed({1'b0, div_rsp.quo[62:0]});
  assign total = acc + 52'($signed(mul_rsp.p[65:16]));
  assign total_wide = 64'(total);
  assign deriv_wide = dq;

  assign s_tready = (state == S_IDLE);
  assign wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // Operand selection for the shared units follows the sequencer state.
  always_comb begin
    mul_req.start = go && (state == S_MI || state == S_MD || state == S_MP ||
                           state == S_MK || state == S_MKD);
    case (state)
      S_MI: begin
        mul_req.a = 34'(error_now);
        mul_req.b = $signed({1'b0, elapsed});
      end
      S_MD: begin
        mul_req.a = diff;
        mul_req.b = $signed({1'b0, pidc_pkg::MS_PER_SECOND});
      end
      S_MP: begin
        mul_req.a = 34'(kp);
        mul_req.b = 33'(error_now);
      end
      S_MK: begin
        mul_req.a = 34'(ki);
        mul_req.b = 33'(integral_sum);
      end
      S_MKD: begin
        mul_req.a = 34'(kd);
        mul_req.b = 33'(deriv);
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
    div_req.start = go && (state == S_DI || state == S_DD);
    div_req.num   = p_mag[63:0];
    div_req.den   = (state == S_DI) ? pidc_pkg::MS_PER_SECOND : elapsed;
  end

  pidc_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  pidc_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      kp     <= '0;
      ki     <= '0;
      kd     <= '0;
      target <= '0;
      offset <= '0;
      bound  <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        pidc_pkg::REG_KP:     kp     <= pwdata;
        pidc_pkg::REG_KI:     ki     <= pwdata;
        pidc_pkg::REG_KD:     kd     <= pwdata;
        pidc_pkg::REG_TARGET: target <= pwdata;
        pidc_pkg::REG_OFFSET: offset <= pwdata;
        pidc_pkg::REG_BOUND:  bound  <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pidc_pkg::REG_KP:     prdata = kp;
      pidc_pkg::REG_KI:     prdata = ki;
      pidc_pkg::REG_KD:     prdata = kd;
      pidc_pkg::REG_TARGET: prdata = target;
      pidc_pkg::REG_OFFSET: prdata = offset;
      pidc_pkg::REG_BOUND:  prdata = {1'b0, bound};
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      go           <= 1'b0;
      primed       <= 1'b0;
      integral_sum <= '0;
      error_now    <= '0;
      error_before <= '0;
      time_before  <= '0;
      clamp_r      <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      go <= 1'b0;
      if (o_valid && m_tready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            time_before  <= now;
            error_before <= error_now;
            clamp_r      <= 1'b0;
            primed       <= 1'b1;
            if (primed) begin
              elapsed   <= now - time_before;
              error_now <= pidc_pkg::sat32(err_wide);
              go        <= 1'b1;
              state     <= S_MI;
            end else begin
              drive_r <= '0;
              state   <= S_DONE;
            end
          end
        end
        S_MI: begin
          if (mul_rsp.done) begin
            quo_neg <= mul_rsp.p[65];
            go      <= 1'b1;
            state   <= S_DI;
          end
        end
        S_DI: begin
          if (div_rsp.done) begin
            step_q <= quo_neg ? -$signed({1'b0, div_rsp.quo[54:0]})
                              : $signed({1'b0, div_rsp.quo[54:0]});
            state  <= S_INT;
          end
        end
        S_INT: begin
          if (sum > bound_pos) begin
            integral_sum <= bound_pos[31:0];
            clamp_r      <= 1'b1;
          end else if (sum < -bound_pos) begin
            integral_sum <= 32'(-bound_pos);
            clamp_r      <= 1'b1;
          end else begin
            integral_sum <= sum[31:0];
          end
          go <= 1'b1;
          if (elapsed == 32'd0) begin
            deriv <= '0;
            state <= S_MP;
          end else begin
            state <= S_MD;
          end
        end
        S_MD: begin
          if (mul_rsp.done) begin
            quo_neg <= mul_rsp.p[65];
            go      <= 1'b1;
            state   <= S_DD;
          end
        end
        S_DD: begin
          if (div_rsp.done) begin
            deriv <= pidc_pkg::sat32(deriv_wide);
            go    <= 1'b1;
            state <= S_MP;
          end
        end
        S_MP: begin
          if (mul_rsp.done) begin
            acc   <= 52'($signed(mul_rsp.p[65:16]));
            go    <= 1'b1;
            state <= S_MK;
          end
        end
        S_MK: begin
          if (mul_rsp.done) begin
            acc   <= total;
            go    <= 1'b1;
            state <= S_MKD;
          end
        end
        S_MKD: begin
          if (mul_rsp.done) begin
            drive_r <= pidc_pkg::sat32(total_wide);
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (!o_valid || m_tready) begin
            o_drive <= drive_r;
            o_error <= error_now;
            o_clamp <= clamp_r;
            o_valid <= 1'b1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {7'd0, o_clamp, o_error, o_drive};

  `PIDC_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready,
                    "block still ready after taking a request")
  `PIDC_ASSERT_SAME(a_no_start_idle, state == S_IDLE, !mul_req.start && !div_req.start,
                    "unit started while idle")
  `PIDC_ASSERT_SAME(a_clamp_value, state == S_DONE && clamp_r,
                    integral_sum == bound_pos[31:0] || integral_sum == 32'(-bound_pos),
                    "clamp flag set but integral is not at the bound")
  `PIDC_ASSERT_SAME(a_mul_done_state, mul_rsp.done,
                    state == S_MI || state == S_MD || state == S_MP ||
                    state == S_MK || state == S_MKD,
                    "multiplier finished outside a multiply step")

endmodule

FILE: rtl/pidc_mul.sv
// ---------------------------------------------------------------------------
// Serial multiplier
// Signed 34 x 33 bit product, one multiplier bit per cycle (shift and add).
// ---------------------------------------------------------------------------
module pidc_mul (
  input  logic               clk,
  input  logic               rst,
  input  pidc_pkg::mul_req_t req,
  output pidc_pkg::mul_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [32:0] amag;
  logic [32:0] hi;
  logic [31:0] lo;
  logic        neg;
  logic [33:0] a_abs;
  logic [32:0] b_abs;
  logic [33:0] t;
  logic [65:0] mag;

  assign a_abs = req.a[33] ? 34'(-req.a) : req.a;
  assign b_abs = req.b[32] ? 33'(-req.b) : req.b;
  assign t = {1'b0, hi} + (lo[0] ? {1'b0, amag} : 34'd0);
  assign mag = {1'b0, hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        amag <= a_abs[32:0];
        lo   <= b_abs[31:0];
        hi   <= '0;
        neg  <= req.a[33] ^ req.b[32];
      end else if (busy) begin
        hi  <= t[33:1];
        lo  <= {t[0], lo[31:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'(pidc_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = neg ? $signed(-mag) : $signed(mag);

endmodule

FILE: rtl/pidc_div.sv
// ---------------------------------------------------------------------------
// Serial divider
// Unsigned 64 / 32 bit restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pidc_div (
  input  logic               clk,
  input  logic               rst,
  input  pidc_pkg::div_req_t req,
  output pidc_pkg::div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] den;
  logic [32:0] r;
  logic        fits;

  assign r    = {rem, quo[63]};
  assign fits = r >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= req.num;
        den  <= req.den;
      end else if (busy) begin
        rem <= fits ? 32'(r - {1'b0, den}) : r[31:0];
        quo <= {quo[62:0], fits};
        cnt <= cnt + 6'd1;
        if (cnt == 6'(pidc_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = quo;

endmodule

FILE: dv/pid_controller_clamped_integral_unit_tb.sv
// ---------------------------------------------------------------------------
// PID controller with clamped integral - testbench
// Streams measurement/timestamp requests through the unit under bursty
// traffic and receiver stalls, and checks every result against a Q16.16
// predictor or a typed-in value, over several gain, setpoint and bound settings.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_controller_clamped_integral_unit_tb;

  typedef struct {
    logic [31:0] drive;
    logic [31:0] err;
    logic        clamp;
  } pid_out_t;

  typedef struct {
    logic [31:0] meas;
    logic [31:0] tms;
    bit          known;
    pid_out_t    res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] measured_value, [63:32] time_ms
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [31:0] drive_value, [63:32] current_error,
                               // [64] integral_clamped, [71:65] zero
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pid_controller_clamped_integral_unit dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor state and configuration.
  logic signed [31:0] kp, ki, kd, setpoint, offset;
  logic [30:0]        bound;
  logic signed [31:0] integ_sum, err_now, err_prev;
  logic [31:0]        t_prev;
  bit                 primed;

  pid_out_t expected_results[$];
  int       mismatches = 0;
  int       burst_left = 0;
  int       ready_pct = 100;

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic pid_out_t pid_step(logic [31:0] meas, logic [31:0] tms);
    pid_out_t o;
    longint   el, e, s, d, lim, total;
    logic [31:0] diff;
    o.drive = '0;
    o.clamp = 1'b0;
    if (primed) begin
      diff = tms - t_prev;
      el = longint'({32'b0, diff});
      e = longint'(setpoint) + longint'(offset) - longint'($signed(meas));
      err_now = clip32(e);
      lim = longint'({33'b0, bound});
      s = longint'(integ_sum) + (longint'(err_now) * el) / 1000;
      if (s > lim) begin
        s = lim;
        o.clamp = 1'b1;
      end else if (s < -lim) begin
        s = -lim;
        o.clamp = 1'b1;
      end
      integ_sum = s[31:0];
      d = 0;
      if (el != 0) d = ((longint'(err_now) - longint'(err_prev)) * 1000) / el;
      d = longint'(clip32(d));
      // Each product is floored to Q16.16 before the exact sum.
      total = ((longint'(kp) * longint'(err_now)) >>> 16)
            + ((longint'(ki) * longint'(integ_sum)) >>> 16)
            + ((longint'(kd) * d) >>> 16);
      o.drive = clip32(total);
    end
    err_prev = err_now;
    t_prev = tms;
    primed = 1'b1;
    o.err = err_now;
    return o;
  endfunction

  // Back-to-back writes keep psel high; the caller closes the transfer.
  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      pidc_pkg::REG_KP:     kp = v;
      pidc_pkg::REG_KI:     ki = v;
      pidc_pkg::REG_KD:     kd = v;
      pidc_pkg::REG_TARGET: setpoint = v;
      pidc_pkg::REG_OFFSET: offset = v;
      pidc_pkg::REG_BOUND:  bound = v[30:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [31:0] p, logic [31:0] i, logic [31:0] d,
                         logic [31:0] sp, logic [31:0] off, logic [31:0] b);
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    reg_write(pidc_pkg::REG_KP, p);
    reg_write(pidc_pkg::REG_KI, i);
    reg_write(pidc_pkg::REG_KD, d);
    reg_write(pidc_pkg::REG_TARGET, sp);
    reg_write(pidc_pkg::REG_OFFSET, off);
    reg_write(pidc_pkg::REG_BOUND, b);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // One request; known rows carry their result typed in, the rest use the predictor.
  task automatic send(logic [31:0] meas, logic [31:0] tms, bit known, pid_out_t res);
    pid_out_t p;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {tms, meas};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    p = pid_step(meas, tms);
    expected_results.push_back(known ? res : p);
  endtask

  // Receiver stalls follow a duty cycle that changes at random times.
  always @(posedge clk) begin
    if ($urandom_range(0, 499) == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pct = 100;
        1: ready_pct = 70;
        2: ready_pct = 25;
        default: ready_pct = 5;
      endcase
    end
    m_tready <= ($urandom_range(0, 99) < ready_pct);
  end

  always @(posedge clk) begin
    pid_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[31:0] !== want.drive || m_tdata[63:32] !== want.err ||
            m_tdata[64] !== want.clamp || m_tdata[71:65] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: drive %h/%h err %h/%h clamp %b/%b (exp/got)",
                     want.drive, m_tdata[31:0], want.err, m_tdata[63:32],
                     want.clamp, m_tdata[64]);
        end
      end
    end
  end

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom();
      default: return $urandom_range(0, 32'h60000) - 32'h30000;
    endcase
  endfunction

  initial begin
    stim_row_t at_reset[4];
    stim_row_t tuned[12];
    pid_out_t  none;
    logic [31:0] t_cur, m;
    none = '{'0, '0, 1'b0};
    kp = 0; ki = 0; kd = 0; setpoint = 0; offset = 0; bound = 0;
    integ_sum = 0; err_now = 0; err_prev = 0; t_prev = 0; primed = 0;

    // With every register at reset the drive is zero and, but for the priming first row, the error is -meas saturated.
    at_reset[0] = '{32'h12345678, 32'd5,  1, '{32'h0, 32'h0, 1'b0}};
    at_reset[1] = '{32'h80000000, 32'd10, 1, '{32'h0, 32'h7fffffff, 1'b1}};
    at_reset[2] = '{32'h7fffffff, 32'd10, 1, '{32'h0, 32'h80000001, 1'b0}};
    at_reset[3] = '{32'h00000000, 32'd0,  1, '{32'h0, 32'h0, 1'b0}};
    // Timestamp zero, wrap, zero elapsed time and measurement extremes.
    tuned[0]  = '{32'h00010000, 32'hfffffff0, 0, none};
    tuned[1]  = '{32'h00020000, 32'h00000010, 0, none};
    tuned[2]  = '{32'h00030000, 32'h00000010, 0, none};
    tuned[3]  = '{32'h7fffffff, 32'h00000011, 0, none};
    tuned[4]  = '{32'h80000000, 32'h00000012, 0, none};
    tuned[5]  = '{32'h80000000, 32'h00000012, 0, none};
    tuned[6]  = '{32'h00000000, 32'h00000000, 0, none};
    tuned[7]  = '{32'hffffffff, 32'hffffffff, 0, none};
    tuned[8]  = '{32'h00040000, 32'h7fffffff, 0, none};
    tuned[9]  = '{32'hfffc0000, 32'h80000000, 0, none};
    tuned[10] = '{32'h00000001, 32'h80000400, 0, none};
    tuned[11] = '{32'h55555555, 32'haaaaaaaa, 0, none};

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (at_reset[i]) send(at_reset[i].meas, at_reset[i].tms, 1, at_reset[i].res);
    set_all(32'h00010000, 32'h00008000, 32'h00000100, 32'h00050000,
            32'hffff0000, 32'h00020000);
    foreach (tuned[i]) send(tuned[i].meas, tuned[i].tms, 0, none);

    t_cur = 32'haaaaaaaa;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0)
        set_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h7fffffff, 32'h7fffffff);
      else if (ph == 1)
        set_all(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'h0);
      else
        set_all(pick_gain(), pick_gain(), pick_gain(),
                $urandom_range(0, 32'h200000) - 32'h100000,
                $urandom_range(0, 1) ? 32'h0 : pick_gain(),
                $urandom_range(0, 2) == 0 ? $urandom() : $urandom_range(0, 32'h400000));
      for (int n = 0; n < 230; n++) begin
        case ($urandom_range(0, 19))
          0: t_cur = $urandom();
          1: ;
          2: t_cur = t_cur + $urandom_range(1000, 100000);
          default: t_cur = t_cur + $urandom_range(1, 60);
        endcase
        if ($urandom_range(0, 9) < 7)
          m = setpoint + offset + $urandom_range(0, 32'h80000) - 32'h40000;
        else
          m = $urandom();
        send(m, t_cur, 0, none);
      end
    end
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/pidc_pkg.sv
rtl/pidc_mul.sv
rtl/pidc_div.sv
rtl/pid_controller_clamped_integral_unit.sv
dv/pid_controller_clamped_integral_unit_tb.sv
